// ===== sv/rpn_stack_calculator_core_assert.svh =====
// Assertion macros shared by the calculator RTL.
`ifndef RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`define RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define RPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn calculator assertion failed");
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn calculator assertion failed");
`define RPN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rpn calculator assertion failed");
`else
`define RPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define RPN_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/rpn_calc_pkg.sv =====
// Types, codes and constants of the RPN stack calculator.
`timescale 1ns / 1ps

package rpn_calc_pkg;

  localparam int STACK_DEPTH_DEFAULT = 128;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 32;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MOD     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRINT   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MOD_ZERO = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd5;

  localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;

  // Divider: 48-bit dividend magnitude, 32-bit divisor, 32 quotient bits.
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;
  localparam int DIV_Q_W = 32;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] shown_value;
    logic                      shown_valid;
    logic [STATUS_W-1:0]       status;
  } out_word_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quo;
    logic [DIV_D_W-1:0] rem;
  } div_res_t;

endpackage

// ===== sv/rpn_calc_divider.sv =====
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module rpn_calc_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             div_start,
  input  logic [rpn_calc_pkg::DIV_N_W-1:0] div_n,
  input  logic [rpn_calc_pkg::DIV_D_W-1:0] div_d,
  output rpn_calc_pkg::div_res_t           div_res
);

  localparam int QW   = rpn_calc_pkg::DIV_Q_W;
  localparam int DW   = rpn_calc_pkg::DIV_D_W;
  localparam int NW   = rpn_calc_pkg::DIV_N_W;
  localparam int CNTW = $clog2(QW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic            ovf_r, ovf_nxt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    ovf_nxt  = ovf_r;
    if (div_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(QW - 1);
      rem_nxt  = DW'(div_n[NW-1:QW]);
      quo_nxt  = div_n[QW-1:0];
      d_nxt    = div_d;
      ovf_nxt  = DW'(div_n[NW-1:QW]) >= div_d;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    d_r   <= d_nxt;
    ovf_r <= ovf_nxt;
  end

  assign div_res.busy = busy_r;
  assign div_res.done = done_r;
  assign div_res.ovf  = ovf_r;
  assign div_res.quo  = quo_r;
  assign div_res.rem  = rem_r;

endmodule

// ===== sv/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: sequencer around the value stack memory.
//
//   Channel  Ports                       Handshake
//   input    start, busy, in_word        word taken when start is high and busy is low
//   result   out_strobe, out_word        one word per input word, shown for one cycle
//
// Push goes straight to the push state; print pops one value; add, subtract and multiply pop two.
// Divide and modulo also wait on the 32-step radix-2 divider.
// An unknown command is answered in the cycle after it is taken.
// Stack reads go through one synchronous port, so each pop takes a pop state and then a get state.
// Reset is synchronous and empties the stack; there is no clearing pass.
// The result word is registered; it cannot be held off.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_core_assert.svh"

module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rpn_calc_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rpn_calc_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output rpn_calc_pkg::out_word_t out_word
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VW  = rpn_calc_pkg::VALUE_W;
  localparam int SW  = rpn_calc_pkg::STATUS_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUSH  = 4'd1;
  localparam logic [3:0] S_POP_B = 4'd2;
  localparam logic [3:0] S_GET_B = 4'd3;
  localparam logic [3:0] S_POP_A = 4'd4;
  localparam logic [3:0] S_GET_A = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;

  function automatic logic [SW-1:0] first_err(input logic [SW-1:0] cur,
                                              input logic [SW-1:0] code);
    first_err = (cur == rpn_calc_pkg::ST_OK) ? code : cur;
  endfunction

  function automatic logic [VW-1:0] mag32(input logic [VW-1:0] v);
    mag32 = v[VW-1] ? (~v + VW'(1)) : v;
  endfunction

  function automatic logic [VW-1:0] sat33(input logic [VW:0] v);
    if (v[VW] != v[VW-1]) begin
      sat33 = v[VW] ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
    end else begin
      sat33 = v[VW-1:0];
    end
  endfunction

  logic [3:0]                state_r, state_nxt;
  logic [SPW-1:0]            sp_r, sp_nxt;
  logic [SW-1:0]             status_r, status_nxt;
  logic                      pop_ok_r, pop_ok_nxt;
  logic [2:0]                mode_r, mode_nxt;
  logic signed [VW-1:0]      a_r, a_nxt;
  logic signed [VW-1:0]      b_r, b_nxt;
  logic [VW-1:0]             res_r, res_nxt;
  logic signed [2*VW-1:0]    prod_r, prod_nxt;
  logic                      out_strobe_r, out_strobe_nxt;
  rpn_calc_pkg::out_word_t   out_word_r, out_word_nxt;

  logic [VW-1:0]             stack_mem [STACK_DEPTH];
  logic [VW-1:0]             rd_data_r;
  logic [SPW-1:0]            sp_dec;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;

  logic                      item_accept;
  logic [VW-1:0]             pop_val;
  logic [VW-1:0]             pop_mag;
  logic [VW-1:0]             a_mag;
  logic [VW-1:0]             b_mag;
  logic [VW:0]               sum_add;
  logic [VW:0]               sum_sub;
  logic                      mul_adj;
  logic [3*VW/2-1:0]         mul_q;
  logic [VW-1:0]             mul_val;
  logic                      div_neg;
  logic [VW-1:0]             div_val;
  logic [VW-1:0]             mod_raw;
  logic [VW-1:0]             mod_val;

  logic                                div_start;
  logic [rpn_calc_pkg::DIV_N_W-1:0]    div_n;
  logic [rpn_calc_pkg::DIV_D_W-1:0]    div_d;
  rpn_calc_pkg::div_res_t              div_res;

  rpn_calc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .div_n     (div_n),
    .div_d     (div_d),
    .div_res   (div_res)
  );

  assign busy        = (state_r != S_IDLE);
  assign item_accept = start && !busy;
  assign out_strobe  = out_strobe_r;
  assign out_word    = out_word_r;

  // A pop always reads in a later cycle than any push write, so no forwarding is needed.
  assign sp_dec  = sp_r - SPW'(1);
  assign rd_addr = sp_dec[AW-1:0];
  assign mem_we  = (state_r == S_PUSH) && (sp_r < SPW'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[sp_r[AW-1:0]] <= res_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  assign pop_val = pop_ok_r ? rd_data_r : '0;
  assign pop_mag = mag32(pop_val);
  assign a_mag   = mag32(a_r);
  assign b_mag   = mag32(b_r);

  assign sum_add = {a_r[VW-1], a_r} + {b_r[VW-1], b_r};
  assign sum_sub = {a_r[VW-1], a_r} - {b_r[VW-1], b_r};

  // Product scaled by 2^-16, rounded toward zero.
  assign mul_adj = prod_r[2*VW-1] && (prod_r[VW/2-1:0] != '0);
  assign mul_q   = prod_r[2*VW-1:VW/2] + {{(3*VW/2-1){1'b0}}, mul_adj};

  always_comb begin
    if ((mul_q[3*VW/2-1:VW-1] == '0) || (mul_q[3*VW/2-1:VW-1] == '1)) begin
      mul_val = mul_q[VW-1:0];
    end else begin
      mul_val = mul_q[3*VW/2-1] ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
    end
  end

  assign div_neg = a_r[VW-1] ^ b_r[VW-1];

  always_comb begin
    priority if (div_res.ovf) begin
      div_val = div_neg ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
    end else if (!div_neg) begin
      div_val = div_res.quo[VW-1] ? rpn_calc_pkg::Q_MAX : div_res.quo;
    end else if (div_res.quo > rpn_calc_pkg::Q_MIN) begin
      div_val = rpn_calc_pkg::Q_MIN;
    end else begin
      div_val = ~div_res.quo + VW'(1);
    end
  end

  assign mod_raw = {div_res.rem[VW/2-1:0], {(VW/2){1'b0}}};
  assign mod_val = a_r[VW-1] ? (~mod_raw + VW'(1)) : mod_raw;

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    status_nxt     = status_r;
    pop_ok_nxt     = pop_ok_r;
    mode_nxt       = mode_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    res_nxt        = res_r;
    prod_nxt       = prod_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    div_start      = 1'b0;
    div_n          = '0;
    div_d          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (item_accept) begin
          mode_nxt   = in_word.mode;
          res_nxt    = in_word.operand_value;
          status_nxt = rpn_calc_pkg::ST_OK;
          unique case (in_word.mode)
            rpn_calc_pkg::MODE_PUSH: begin
              state_nxt = S_PUSH;
            end
            rpn_calc_pkg::MODE_UNKNOWN: begin
              out_strobe_nxt           = 1'b1;
              out_word_nxt.shown_value = '0;
              out_word_nxt.shown_valid = 1'b0;
              out_word_nxt.status      = rpn_calc_pkg::ST_UNKNOWN;
            end
            default: begin
              state_nxt = S_POP_B;
            end
          endcase
        end
      end
      S_POP_B, S_POP_A: begin
        if (sp_r != '0) begin
          sp_nxt     = sp_dec;
          pop_ok_nxt = 1'b1;
        end else begin
          pop_ok_nxt = 1'b0;
          status_nxt = first_err(status_r, rpn_calc_pkg::ST_EMPTY);
        end
        state_nxt = (state_r == S_POP_B) ? S_GET_B : S_GET_A;
      end
      S_GET_B: begin
        priority if (mode_r == rpn_calc_pkg::MODE_PRINT) begin
          out_strobe_nxt           = 1'b1;
          out_word_nxt.shown_value = pop_val;
          out_word_nxt.shown_valid = 1'b1;
          out_word_nxt.status      = status_r;
          state_nxt                = S_IDLE;
        end else if ((mode_r == rpn_calc_pkg::MODE_DIV) && (pop_val == '0)) begin
          out_strobe_nxt           = 1'b1;
          out_word_nxt.shown_value = '0;
          out_word_nxt.shown_valid = 1'b0;
          out_word_nxt.status      = first_err(status_r, rpn_calc_pkg::ST_ZERO_DIV);
          state_nxt                = S_IDLE;
        end else if ((mode_r == rpn_calc_pkg::MODE_MOD) && (pop_mag[VW-1:VW/2] == '0)) begin
          out_strobe_nxt           = 1'b1;
          out_word_nxt.shown_value = '0;
          out_word_nxt.shown_valid = 1'b0;
          out_word_nxt.status      = first_err(status_r, rpn_calc_pkg::ST_MOD_ZERO);
          state_nxt                = S_IDLE;
        end else begin
          b_nxt     = pop_val;
          state_nxt = S_POP_A;
        end
      end
      S_GET_A: begin
        a_nxt     = pop_val;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (mode_r)
          rpn_calc_pkg::MODE_ADD: begin
            res_nxt   = sat33(sum_add);
            state_nxt = S_PUSH;
          end
          rpn_calc_pkg::MODE_SUB: begin
            res_nxt   = sat33(sum_sub);
            state_nxt = S_PUSH;
          end
          rpn_calc_pkg::MODE_MUL: begin
            prod_nxt  = (2*VW)'(a_r) * (2*VW)'(b_r);
            state_nxt = S_MUL;
          end
          rpn_calc_pkg::MODE_DIV: begin
            div_start = 1'b1;
            div_n     = {a_mag, {(VW/2){1'b0}}};
            div_d     = b_mag;
            state_nxt = S_DIV;
          end
          rpn_calc_pkg::MODE_MOD: begin
            div_start = 1'b1;
            div_n     = {{(VW){1'b0}}, a_mag[VW-1:VW/2]};
            div_d     = {{(VW/2){1'b0}}, b_mag[VW-1:VW/2]};
            state_nxt = S_DIV;
          end
          default: begin
            state_nxt = S_PUSH;
          end
        endcase
      end
      S_MUL: begin
        res_nxt   = mul_val;
        state_nxt = S_PUSH;
      end
      S_DIV: begin
        if (div_res.done) begin
          res_nxt   = (mode_r == rpn_calc_pkg::MODE_MOD) ? mod_val : div_val;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        out_strobe_nxt           = 1'b1;
        out_word_nxt.shown_value = '0;
        out_word_nxt.shown_valid = 1'b0;
        if (sp_r < SPW'(STACK_DEPTH)) begin
          sp_nxt              = sp_r + SPW'(1);
          out_word_nxt.status = status_r;
        end else begin
          out_word_nxt.status = first_err(status_r, rpn_calc_pkg::ST_FULL);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      status_r     <= rpn_calc_pkg::ST_OK;
      pop_ok_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      status_r     <= status_nxt;
      pop_ok_r     <= pop_ok_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  `RPN_ASSERT_NEVER(a_sp_range, clk, rst_n, sp_r > SPW'(STACK_DEPTH))
  `RPN_ASSERT_NEXT(a_accept_busy, clk, rst_n, item_accept && (in_word.mode != rpn_calc_pkg::MODE_UNKNOWN), busy)
  `RPN_ASSERT_IMP(a_shown_zero, clk, rst_n, out_strobe && !out_word.shown_valid, out_word.shown_value == '0)
  `RPN_ASSERT_IMP(a_div_free, clk, rst_n, div_start, !div_res.busy && (state_r == S_EXEC))
  `RPN_ASSERT_IMP(a_sp_step, clk, rst_n, sp_r != $past(sp_r), (sp_r == $past(sp_r) + SPW'(1)) || (sp_r == $past(sp_r) - SPW'(1)))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the RPN stack calculator core with its own token evaluator.
`timescale 1ns / 1ps

module tb_top;
  import rpn_calc_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_WORDS = 350;
  localparam int IDLE_PCT [4] = '{0, 79, 8, 0};

  localparam logic signed [VALUE_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [VALUE_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [VALUE_W-1:0] LIMIT_VALUES [5] =
    '{Q_MAX, Q_MIN, 32'sh0, Q_ONE, Q_NEG_ONE};
  localparam logic [MODE_W-1:0] ARITH_MODES [5] =
    '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD};

  typedef struct {
    in_word_t  token;
    bit        fixed;
    out_word_t answer;
  } token_row_t;

  token_row_t directed_rows [25] = '{
    '{'{MODE_PRINT,   32'sh0},          1'b1, '{32'sh0, 1'b1, ST_EMPTY}},
    '{'{MODE_ADD,     32'sh0},          1'b1, '{32'sh0, 1'b0, ST_EMPTY}},
    '{'{MODE_PRINT,   32'sh0},          1'b1, '{32'sh0, 1'b1, ST_OK}},
    '{'{MODE_UNKNOWN, 32'shFFFF_FFFF},  1'b1, '{32'sh0, 1'b0, ST_UNKNOWN}},
    '{'{MODE_PUSH,    Q_MAX},           1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PUSH,    Q_ONE},           1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_ADD,     32'sh0},          1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PRINT,   32'sh0},          1'b1, '{Q_MAX,  1'b1, ST_OK}},
    '{'{MODE_PUSH,    Q_MIN},           1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PUSH,    Q_ONE},           1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_SUB,     32'sh0},          1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PRINT,   32'sh0},          1'b1, '{Q_MIN,  1'b1, ST_OK}},
    '{'{MODE_PUSH,    32'sh0005_0000},  1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PUSH,    32'sh0},          1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_DIV,     32'sh0},          1'b1, '{32'sh0, 1'b0, ST_ZERO_DIV}},
    '{'{MODE_PUSH,    32'sh0000_8000},  1'b1, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_MOD,     32'sh0},          1'b1, '{32'sh0, 1'b0, ST_MOD_ZERO}},
    '{'{MODE_PUSH,    32'sh0003_0000},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_MUL,     32'sh7FFF_FFFF},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PUSH,    32'sh0004_0000},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_MOD,     32'sh8000_0000},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PUSH,    32'shFFFE_0000},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_DIV,     32'sh5555_AAAA},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_PRINT,   32'shAAAA_5555},  1'b0, '{32'sh0, 1'b0, ST_OK}},
    '{'{MODE_DIV,     32'sh0},          1'b1, '{32'sh0, 1'b0, ST_EMPTY}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  logic signed [VALUE_W-1:0] calc_stack [DEPTH];
  int unsigned               calc_depth;
  logic [STATUS_W-1:0]       token_status;

  out_word_t expected_words [$];
  out_word_t oldest_word;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  int        fill_left = 0;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VALUE_W-1:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[VALUE_W-1:0];
  endfunction

  function automatic void note_status(input logic [STATUS_W-1:0] code);
    if (token_status == ST_OK) token_status = code;
  endfunction

  function automatic void push_value(input logic signed [VALUE_W-1:0] v);
    if (calc_depth < DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      note_status(ST_FULL);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] pop_value();
    if (calc_depth > 0) begin
      calc_depth--;
      return calc_stack[calc_depth];
    end
    note_status(ST_EMPTY);
    return '0;
  endfunction

  function automatic out_word_t evaluate_token(input in_word_t w);
    out_word_t r;
    longint    a;
    longint    b;
    r = '0;
    token_status = ST_OK;
    case (w.mode)
      MODE_PUSH: push_value(w.operand_value);
      MODE_ADD: begin
        b = pop_value();
        a = pop_value();
        push_value(clamp_q(a + b));
      end
      MODE_SUB: begin
        b = pop_value();
        a = pop_value();
        push_value(clamp_q(a - b));
      end
      MODE_MUL: begin
        b = pop_value();
        a = pop_value();
        push_value(clamp_q((a * b) / 64'sd65536));
      end
      MODE_DIV: begin
        b = pop_value();
        if (b == 0) begin
          note_status(ST_ZERO_DIV);
        end else begin
          a = pop_value();
          push_value(clamp_q((a * 64'sd65536) / b));
        end
      end
      MODE_MOD: begin
        b = pop_value();
        b = b / 64'sd65536;
        if (b == 0) begin
          note_status(ST_MOD_ZERO);
        end else begin
          a = pop_value();
          a = a / 64'sd65536;
          push_value(clamp_q((a % b) * 64'sd65536));
        end
      end
      MODE_PRINT: begin
        r.shown_value = pop_value();
        r.shown_valid = 1'b1;
      end
      default: note_status(ST_UNKNOWN);
    endcase
    r.status = token_status;
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_operand();
    int v;
    case ($urandom_range(5, 0))
      0, 1: v = $urandom;
      2: v = ($urandom_range(16, 0) - 8) * 65536 + $urandom_range(65535, 0);
      3: v = ($urandom_range(16, 0) - 8) * 65536;
      4: v = $urandom_range(1, 0) ? $urandom_range(65535, 0) : -$urandom_range(65535, 0);
      default: v = LIMIT_VALUES[$urandom_range(4, 0)];
    endcase
    return v;
  endfunction

  function automatic in_word_t next_token();
    in_word_t    w;
    int unsigned r;
    w.operand_value = pick_operand();
    r = $urandom_range(99, 0);
    if (fill_left > 0) begin
      w.mode = MODE_PUSH;
      if (calc_depth == DEPTH) fill_left--;
    end else if (r < 4) begin
      w.mode = MODE_W'($urandom_range(7, 0));
    end else if ((calc_depth < 2 && r < 80) || r < 39) begin
      w.mode = MODE_PUSH;
    end else if (r < 89) begin
      w.mode = ARITH_MODES[$urandom_range(4, 0)];
    end else begin
      w.mode = MODE_PRINT;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t answer);
    out_word_t e;
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = evaluate_token(w);
    expected_words.push_back(fixed ? answer : e);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %h", out_word);
        mismatches++;
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_word.shown_value !== oldest_word.shown_value) begin
          $error("shown_value: expected %h, got %h", oldest_word.shown_value,
                 out_word.shown_value);
          mismatches++;
        end
        if (out_word.shown_valid !== oldest_word.shown_valid) begin
          $error("shown_valid: expected %b, got %b", oldest_word.shown_valid,
                 out_word.shown_valid);
          mismatches++;
        end
        if (out_word.status !== oldest_word.status) begin
          $error("status: expected %0d, got %0d", oldest_word.status, out_word.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    calc_depth = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].token, directed_rows[i].fixed, directed_rows[i].answer);
    end
    settle();
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = IDLE_PCT[phase];
      fill_left = (phase == 1) ? 0 : $urandom_range(3, 1);
      repeat (PHASE_WORDS) send_word(next_token(), 1'b0, '0);
      settle();
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
